// File: rtl/frame_bit_deinterleaver_top_macros.svh
// Assertion macros shared by the frame bit deinterleaver RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef FRAME_BIT_DEINTERLEAVER_TOP_MACROS_SVH
`define FRAME_BIT_DEINTERLEAVER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define FBD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds.
`define FBD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`FBD_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define FBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FBD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/fbd_pkg.sv
// Shared types and constants of the frame bit deinterleaver.
// No dependencies; imported by every RTL module of the block.
package fbd_pkg;

	localparam int FRAME_LEN_W = 16;
	localparam int BPS_W       = 3;
	localparam int ORDER_W     = 15;
	localparam int SOFT_W      = 8;
	localparam int BLOCK_W     = 3;

	localparam int MAX_FRAME_DEF   = 65536;
	localparam int MAX_COLUMNS_DEF = 5;
	localparam int OP_QUEUE_DEPTH  = 4;

	// Bank bit plus position within a bank, for the largest frame.
	localparam int BANK_AW_MAX = 17;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SYMBOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_ORDER    = 2'd2;

	localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RST    = 16'd64800;
	localparam logic [BPS_W-1:0]       BITS_PER_SYMBOL_RST = 3'd2;
	localparam logic [ORDER_W-1:0]     COLUMN_ORDER_RST    = 15'd18056;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic signed [SOFT_W-1:0] soft_bit;
	} in_item_t;

	typedef struct packed {
		logic signed [SOFT_W-1:0] bit_out;
		logic                     last_of_frame;
	} out_item_t;

	// One bank operation: an optional readout and an optional store.
	typedef struct packed {
		logic                     rd_en;
		logic [BANK_AW_MAX-1:0]   rd_addr;
		logic                     last;
		logic                     wr_en;
		logic [BANK_AW_MAX-1:0]   wr_addr;
		logic signed [SOFT_W-1:0] wr_data;
	} op_t;

endpackage

// File: rtl/fbd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on fbd_pkg for its parameter defaults; no reset on the storage.
module fbd_ram
	import fbd_pkg::*;
#(
	parameter int WIDTH = SOFT_W,
	parameter int DEPTH = 2 * MAX_FRAME_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/fbd_queue.sv
// Short register queue of bank operations between front and back end.
// Depends on fbd_pkg for op_t and the default depth.
`include "frame_bit_deinterleaver_top_macros.svh"

module fbd_queue
	import fbd_pkg::*;
#(
	parameter int DEPTH = OP_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  op_in,
	output logic full,
	input  logic pop,
	output op_t  op_out,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign op_out  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// The front end must hold back whenever the queue is full.
	`FBD_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && full, "op pushed into full queue")

endmodule

// File: rtl/fbd_front.sv
// Front end: configuration registers, row count divider, frame counters and
// bank address generation. Depends on fbd_pkg and the assertion macros.
`include "frame_bit_deinterleaver_top_macros.svh"

module fbd_front
	import fbd_pkg::*;
#(
	parameter int MAX_FRAME   = MAX_FRAME_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              sample,
	output logic                  full,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  op_push,
	output op_t                   op
);

	localparam int POS_W  = $clog2(MAX_FRAME);
	localparam int LEN_W  = $clog2(MAX_FRAME + 1);
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int M_W    = $clog2(MAX_COLUMNS + 1);
	localparam int OFF_W  = LEN_W + BLOCK_W;
	localparam int WA_W   = OFF_W + 1;
	localparam int CNT_W  = $clog2(LEN_W);
	localparam int NSLOT  = 1 << COL_W;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ROWS = 3'd2;
	localparam logic [2:0] ST_OFFS = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	function automatic logic [BLOCK_W-1:0] block_of(input logic [ORDER_W-1:0] order,
			input logic [COL_W-1:0] c);
		logic [BLOCK_W*NSLOT-1:0] wide;
		wide = (BLOCK_W*NSLOT)'(order);
		return wide[BLOCK_W*c +: BLOCK_W];
	endfunction

	logic [FRAME_LEN_W-1:0] frame_length_q;
	logic [BPS_W-1:0]       bps_q;
	logic [ORDER_W-1:0]     order_q;
	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [LEN_W-1:0]       div_q;
	logic [M_W-1:0]         rem_q;
	logic [LEN_W-1:0]       rows_q;
	logic [LEN_W-1:0]       len_q;
	logic [OFF_W-1:0]       off_q [NSLOT];

	logic [POS_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [POS_W-1:0]       rpos_q;
	logic                   wb_q;
	logic                   pending_q;

	logic [M_W-1:0]         m_eff;
	logic [LEN_W-1:0]       len_cap;
	logic [M_W:0]           trial;
	logic                   ge;
	logic                   accept;
	logic                   is_data;
	logic                   rd_last;
	logic                   col_last;
	logic                   row_last;
	logic                   frame_done;
	logic [WA_W-1:0]        lin_addr;
	logic [WA_W-1:0]        blk_addr;
	logic [WA_W-1:0]        wa;

	// Clamp the column count and the frame length to what the banks hold.
	always_comb begin
		if (bps_q == '0) begin
			m_eff = M_W'(1);
		end else if (M_W'(bps_q) > M_W'(MAX_COLUMNS)) begin
			m_eff = M_W'(MAX_COLUMNS);
		end else begin
			m_eff = M_W'(bps_q);
		end
		if (32'(frame_length_q) > MAX_FRAME) begin
			len_cap = LEN_W'(MAX_FRAME);
		end else begin
			len_cap = LEN_W'(frame_length_q);
		end
	end

	// One restoring step of len_cap / m_eff per cycle.
	assign trial = {rem_q, div_q[LEN_W-1]};
	assign ge    = (trial >= {1'b0, m_eff});

	assign accept   = push && !full;
	assign is_data  = (sample.kind == KIND_DATA);
	assign rd_last  = ((LEN_W+1)'(rpos_q) + 1'b1) >= (LEN_W+1)'(len_q);
	assign col_last = ((M_W+1)'(col_q) + 1'b1) >= (M_W+1)'(m_eff);
	assign row_last = ((LEN_W+1)'(row_q) + 1'b1) >= (LEN_W+1)'(rows_q);
	assign frame_done = accept && is_data && col_last && row_last;

	// Small column counts store in arrival order; others go by row block.
	assign lin_addr = ((m_eff == M_W'(2)) ? (WA_W'(row_q) << 1) : WA_W'(row_q))
		+ WA_W'(col_q);
	assign blk_addr = WA_W'(off_q[col_q]) + WA_W'(row_q);
	assign wa       = (m_eff <= M_W'(2)) ? lin_addr : blk_addr;

	always_comb begin
		op.rd_en   = pending_q;
		op.rd_addr = BANK_AW_MAX'({~wb_q, rpos_q});
		op.last    = rd_last;
		op.wr_en   = is_data && (wa < WA_W'(MAX_FRAME));
		op.wr_addr = BANK_AW_MAX'({wb_q, wa[POS_W-1:0]});
		op.wr_data = sample.soft_bit;
	end

	assign op_push = accept && (op.rd_en || op.wr_en);
	assign full    = (state_q != ST_RUN) || q_full;

	// Divider and scaling datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				div_q <= len_cap;
				rem_q <= '0;
			end
			ST_DIV: begin
				div_q <= {div_q[LEN_W-2:0], ge};
				rem_q <= ge ? M_W'(trial - {1'b0, m_eff}) : trial[M_W-1:0];
			end
			ST_ROWS: begin
				rows_q <= (div_q == '0) ? LEN_W'(1) : div_q;
			end
			ST_OFFS: begin
				for (int c = 0; c < NSLOT; c++) begin
					off_q[c] <= OFF_W'(block_of(order_q, COL_W'(c))) * OFF_W'(rows_q);
				end
				len_q <= LEN_W'((LEN_W+M_W)'(rows_q) * (LEN_W+M_W)'(m_eff));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_LENGTH_RST;
			bps_q          <= BITS_PER_SYMBOL_RST;
			order_q        <= COLUMN_ORDER_RST;
			state_q        <= ST_LOAD;
			cnt_q          <= '0;
			row_q          <= '0;
			col_q          <= '0;
			rpos_q         <= '0;
			wb_q           <= 1'b0;
			pending_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LEN_W - 1)) begin
						state_q <= ST_ROWS;
					end
				end
				ST_ROWS: state_q <= ST_OFFS;
				ST_OFFS: state_q <= ST_RUN;
				ST_RUN:  state_q <= ST_RUN;
				default: state_q <= ST_LOAD;
			endcase

			// Any write restarts the size computation.
			if (cfg_write) begin
				state_q <= ST_LOAD;
				case (cfg_index)
					REG_FRAME_LENGTH:    frame_length_q <= cfg_data[FRAME_LEN_W-1:0];
					REG_BITS_PER_SYMBOL: bps_q          <= cfg_data[BPS_W-1:0];
					REG_COLUMN_ORDER:    order_q        <= cfg_data[ORDER_W-1:0];
					default: begin
					end
				endcase
			end

			if (accept) begin
				// Readout of the pending frame first.
				if (pending_q) begin
					if (rd_last) begin
						pending_q <= 1'b0;
						rpos_q    <= '0;
					end else begin
						rpos_q <= rpos_q + 1'b1;
					end
				end
				// Then advance the write counters; a full frame swaps banks.
				if (is_data) begin
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q     <= '0;
							wb_q      <= ~wb_q;
							pending_q <= 1'b1;
							rpos_q    <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	`FBD_ASSERT(a_frame_swap, clk, arst_n, frame_done |=> pending_q && rpos_q == '0 && wb_q != $past(wb_q), "frame end did not swap banks")
	`FBD_ASSERT(a_col_bound, clk, arst_n, (M_W+1)'(col_q) < (M_W+1)'(MAX_COLUMNS), "column counter out of range")

endmodule

// File: rtl/fbd_back.sv
// Back end: executes bank operations on the frame RAM and buffers results.
// Depends on fbd_pkg, fbd_ram and the assertion macros.
`include "frame_bit_deinterleaver_top_macros.svh"

module fbd_back
	import fbd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  op_t       op,
	input  logic      op_avail,
	output logic      op_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int POS_W    = $clog2(MAX_FRAME);
	localparam int RAM_AW   = POS_W + 1;
	localparam int OUT_SLOT = 2;

	out_item_t                buf_q [OUT_SLOT];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               count_q;
	logic                     inflight_s1;
	logic                     last_s1;
	logic [1:0]               total;
	logic                     pop_ok;
	logic                     rd_room;
	logic                     rd_issue;
	logic                     wr_issue;
	logic [SOFT_W-1:0]        rdata;
	out_item_t                fresh;

	assign pop_ok   = pop && !empty;
	assign total    = count_q + 2'(inflight_s1);
	// Reserve a buffer slot before a read leaves for the RAM.
	assign rd_room  = (total < 2'(OUT_SLOT)) || pop_ok;
	assign op_take  = op_avail && (!op.rd_en || rd_room);
	assign rd_issue = op_take && op.rd_en;
	assign wr_issue = op_take && op.wr_en;

	fbd_ram #(
		.WIDTH(SOFT_W),
		.DEPTH(2 << POS_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_issue),
		.waddr(op.wr_addr[RAM_AW-1:0]),
		.wdata(op.wr_data),
		.re   (rd_issue),
		.raddr(op.rd_addr[RAM_AW-1:0]),
		.rdata(rdata)
	);

	assign fresh.bit_out       = rdata;
	assign fresh.last_of_frame = last_s1;

	assign empty  = (count_q == '0);
	assign result = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			last_s1 <= op.last;
		end
		if (inflight_s1) begin
			buf_q[wr_ptr_q] <= fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			count_q     <= '0;
		end else begin
			inflight_s1 <= rd_issue;
			if (inflight_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(inflight_s1) - 2'(pop_ok);
		end
	end

	`FBD_ASSERT_NEVER(a_out_overflow, clk, arst_n, inflight_s1 && count_q == 2'(OUT_SLOT) && !pop_ok, "result buffer overflow")
	`FBD_ASSERT_NEVER(a_bank_clash, clk, arst_n, rd_issue && wr_issue && op.rd_addr == op.wr_addr, "read and write hit one entry")

endmodule

// File: rtl/frame_bit_deinterleaver_top.sv
// Top level of the frame bit deinterleaver; ties front end, op queue and
// back end together. Depends on fbd_pkg, fbd_front, fbd_queue, fbd_back.
//
// Column-to-row soft-bit deinterleaver with two ping-pong frame banks. Push
// one item per cycle: a data item carries a soft bit that is stored at its
// deinterleaved position in the bank being filled; while a frame waits in
// the other bank, every item, data or drain, pops one bit of that frame in
// order, flagged on its final bit. The sustained rate is one item per clock
// while the op queue and result buffer keep up. The bank RAM has one write
// and one registered read port, so an item's readout and store share one
// RAM access; a result passes the op queue and the registered read before
// it lands in the result buffer. After reset and after every configuration
// write, full stays high while a one-bit-per-cycle divider works out the
// rows per frame and the row-block offsets. The banks are not cleared;
// software loads frame_length, bits_per_symbol and column_order (a
// permutation) only while the block is idle.
module frame_bit_deinterleaver_top
	import fbd_pkg::*;
#(
	parameter int MAX_FRAME   = MAX_FRAME_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              sample,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Front to queue: one bank operation per accepted item that reads or stores.
	op_t  f_op;
	logic f_push;
	logic q_full;
	// Queue to back end.
	op_t  q_op;
	logic q_empty;
	logic q_take;

	// Accept and classify items; generate bank addresses.
	fbd_front #(
		.MAX_FRAME  (MAX_FRAME),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.op_push  (f_push),
		.op       (f_op)
	);

	// Decouple the two halves so either side can stall on its own.
	fbd_queue #(
		.DEPTH(OP_QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.op_in (f_op),
		.full  (q_full),
		.pop   (q_take),
		.op_out(q_op),
		.empty (q_empty)
	);

	// Execute operations on the banks and hold results until popped.
	fbd_back #(
		.MAX_FRAME(MAX_FRAME)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (q_op),
		.op_avail(!q_empty),
		.op_take (q_take),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: dv/tb_frame_bit_deinterleaver_top.sv
// Self-checking testbench of frame_bit_deinterleaver_top: directed and random
// frames against an in-bench deinterleaver model, with random back-pressure.
// Depends on fbd_pkg and the frame_bit_deinterleaver_top RTL.
`timescale 1ns / 100ps

module tb_frame_bit_deinterleaver_top;
	import fbd_pkg::*;

	// Index 3 decodes to no register; writes there must change no register.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DATA_PER_SETTING = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t sample = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frame_bit_deinterleaver_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Items waiting to be pushed, and deinterleaved bits waiting to pop out.
	in_item_t sample_queue[$];
	out_item_t expected_bits[$];
	logic item_taken = 1'b0;
	int errors = 0;
	int cycle_count = 0;

	// Idle odds in percent, and a one-shot request for a long pop hold-off.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	// Shadow of the registers and of the block state.
	logic [FRAME_LEN_W-1:0] len_reg = FRAME_LENGTH_RST;
	logic [BPS_W-1:0] bps_reg = BITS_PER_SYMBOL_RST;
	logic [ORDER_W-1:0] order_reg = COLUMN_ORDER_RST;
	logic signed [SOFT_W-1:0] bank_mem [0:2*MAX_FRAME_DEF-1];
	logic [FRAME_LEN_W-1:0] row_cnt = '0;
	logic [BPS_W-1:0] col_cnt = '0;
	logic [FRAME_LEN_W-1:0] rd_pos = '0;
	logic wr_bank = 1'b0;
	logic frame_waiting = 1'b0;

	// Frame size in items of the current setting, used by the stimulus.
	int cur_frame;

	// Zero columns act as one, more than the maximum as the maximum.
	function automatic int column_count(input logic [BPS_W-1:0] bps);
		if (bps == 0)
			return 1;
		if (int'(bps) > MAX_COLUMNS_DEF)
			return MAX_COLUMNS_DEF;
		return int'(bps);
	endfunction

	// Rows per frame, never below one; the 16-bit length is below MAX_FRAME.
	function automatic int row_count(input logic [FRAME_LEN_W-1:0] len, input int m);
		int r;
		r = int'(len) / m;
		return (r == 0) ? 1 : r;
	endfunction

	// Work out one accepted item: read the waiting frame first, then store
	// the soft bit, then check for the end of the frame being filled.
	task automatic deinterleave_item(input in_item_t it);
		int m;
		int rows;
		int flen;
		int addr;
		logic [BLOCK_W-1:0] blk;
		out_item_t want;
		m = column_count(bps_reg);
		rows = row_count(len_reg, m);
		flen = rows * m;
		if (frame_waiting) begin
			want.bit_out = bank_mem[(1 - int'(wr_bank)) * MAX_FRAME_DEF + int'(rd_pos)];
			want.last_of_frame = (int'(rd_pos) + 1 >= flen);
			if (want.last_of_frame) begin
				frame_waiting = 1'b0;
				rd_pos = '0;
			end else begin
				rd_pos = rd_pos + 1'b1;
			end
			expected_bits.push_back(want);
		end
		if (it.kind == KIND_DATA) begin
			if (m <= 2) begin
				addr = int'(row_cnt) * m + int'(col_cnt);
			end else begin
				blk = BLOCK_W'((order_reg >> (3 * int'(col_cnt))) & 15'h7);
				addr = int'(blk) * rows + int'(row_cnt);
			end
			// Drop stores past the bank, as a bad order would cause.
			if (addr < MAX_FRAME_DEF)
				bank_mem[int'(wr_bank) * MAX_FRAME_DEF + addr] = it.soft_bit;
			if (int'(col_cnt) + 1 >= m) begin
				col_cnt = '0;
				if (int'(row_cnt) + 1 >= rows) begin
					row_cnt = '0;
					wr_bank = ~wr_bank;
					frame_waiting = 1'b1;
					rd_pos = '0;
				end else begin
					row_cnt = row_cnt + 1'b1;
				end
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
		end
	endtask

	// Monitor: sample everything at the rising edge. Check the popped bit
	// before predicting, so a stray result cannot hide behind a new one.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bits.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual bit_out %0d last %0b",
						$time, result.bit_out, result.last_of_frame);
					errors++;
				end else begin
					want = expected_bits.pop_front();
					if (result.bit_out !== want.bit_out) begin
						$display("%0t: bit_out mismatch, expected %0d actual %0d",
							$time, want.bit_out, result.bit_out);
						errors++;
					end
					if (result.last_of_frame !== want.last_of_frame) begin
						$display("%0t: last_of_frame mismatch, expected %0b actual %0b",
							$time, want.last_of_frame, result.last_of_frame);
						errors++;
					end
				end
			end
			if (push && !full) begin
				deinterleave_item(sample);
				item_taken = 1'b1;
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_FRAME_LENGTH: begin
						len_reg = cfg_data[FRAME_LEN_W-1:0];
					end
					REG_BITS_PER_SYMBOL: begin
						bps_reg = cfg_data[BPS_W-1:0];
					end
					REG_COLUMN_ORDER: begin
						order_reg = cfg_data[ORDER_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Bound the run; a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Driver: retire the item taken at the last rising edge, then offer the
	// next one or idle. One nonblocking write of push per falling edge.
	always @(negedge clk) begin
		if (item_taken) begin
			void'(sample_queue.pop_front());
			item_taken = 1'b0;
		end
		if (arst_n && sample_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
			push <= 1'b1;
			sample <= sample_queue[0];
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: random pop gaps, plus a long hold-off counted here.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic queue_item(input logic kind, input logic [SOFT_W-1:0] soft_val);
		in_item_t it;
		it.kind = kind;
		it.soft_bit = soft_val;
		sample_queue.push_back(it);
	endtask

	// Hold until every item is in and every bit is out, then let the
	// pipeline settle, since a drain item may still be in flight.
	task automatic wait_for_idle();
		@(negedge clk);
		while (sample_queue.size() != 0 || expected_bits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	// Random order; above two columns the fields of the used columns form a permutation.
	function automatic logic [ORDER_W-1:0] random_order(input int m);
		int perm[MAX_COLUMNS_DEF];
		int k;
		int j;
		int t;
		logic [ORDER_W-1:0] o;
		o = ORDER_W'($urandom);
		for (k = 0; k < m; k++)
			perm[k] = k;
		for (k = m - 1; k > 0; k--) begin
			j = $urandom_range(k);
			t = perm[k];
			perm[k] = perm[j];
			perm[j] = t;
		end
		if (m > 2) begin
			for (k = 0; k < m; k++)
				o[3*k +: 3] = 3'(perm[k]);
		end
		return o;
	endfunction

	// Load a setting while idle. Unused upper data bits carry noise.
	task automatic load_setting(input logic [FRAME_LEN_W-1:0] len,
			input logic [BPS_W-1:0] bps, input logic [ORDER_W-1:0] order);
		int m;
		wait_for_idle();
		write_reg(REG_FRAME_LENGTH, len);
		write_reg(REG_BITS_PER_SYMBOL, {13'($urandom), bps});
		write_reg(REG_COLUMN_ORDER, {1'($urandom), order});
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		m = column_count(bps);
		cur_frame = row_count(len, m) * m;
	endtask

	// Whole frames with drain items sprinkled in, then enough drains to
	// empty the last frame, so no setting ends inside a frame.
	task automatic fill_frames(input int frames);
		int f;
		int i;
		for (f = 0; f < frames; f++) begin
			for (i = 0; i < cur_frame; i++) begin
				if ($urandom_range(99) < 15)
					queue_item(KIND_DRAIN, SOFT_W'($urandom));
				queue_item(KIND_DATA, SOFT_W'($urandom));
			end
		end
		for (i = 0; i < cur_frame; i++)
			queue_item(KIND_DRAIN, SOFT_W'($urandom));
	endtask

	// Walk bits_per_symbol through all eight codes; lengths mostly small,
	// sometimes the zero and one corners.
	task automatic random_setting(input int k);
		logic [BPS_W-1:0] bps;
		logic [FRAME_LEN_W-1:0] len;
		int sel;
		int frames;
		bps = BPS_W'(k % 8);
		sel = $urandom_range(9);
		if (sel == 0)
			len = '0;
		else if (sel == 1)
			len = 16'd1;
		else
			len = FRAME_LEN_W'($urandom_range(48, 2));
		load_setting(len, bps, random_order(column_count(bps)));
		frames = DATA_PER_SETTING / cur_frame;
		fill_frames((frames == 0) ? 1 : frames);
	endtask

	initial begin
		int k;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		tx_idle_pct = 26;
		rx_idle_pct = 75;

		// Drains at the reset setting: nothing waits, nothing comes out.
		queue_item(KIND_DRAIN, 8'h00);
		queue_item(KIND_DRAIN, 8'hFF);

		// Three columns, two rows, order 1,2,0: extremes of the soft bit.
		load_setting(16'd6, 3'd3, 15'h7E11);
		queue_item(KIND_DATA, 8'h7F);
		queue_item(KIND_DATA, 8'h80);
		queue_item(KIND_DATA, 8'h00);
		queue_item(KIND_DATA, 8'hFF);
		queue_item(KIND_DATA, 8'h01);
		queue_item(KIND_DATA, 8'h55);
		for (k = 0; k < 6; k++)
			queue_item(KIND_DRAIN, 8'hAA);

		// One-bit frames: every data item closes a frame.
		load_setting(16'd1, 3'd1, 15'h0000);
		queue_item(KIND_DATA, 8'h80);
		queue_item(KIND_DATA, 8'h7F);
		queue_item(KIND_DRAIN, 8'h00);

		// Zero length and an oversize column count: one row of five,
		// reversed order.
		load_setting(16'd0, 3'd7, 15'd668);
		for (k = 0; k < 5; k++)
			queue_item(KIND_DATA, SOFT_W'($urandom));
		for (k = 0; k < 5; k++)
			queue_item(KIND_DRAIN, SOFT_W'($urandom));

		for (k = 0; k < 4; k++)
			random_setting(k);

		wait_for_idle();
		tx_idle_pct = 75;
		rx_idle_pct = 26;

		// Hold pop off long enough for results to back up and fill the block.
		load_setting(16'd24, 3'd4, random_order(4));
		fill_frames(4);
		hold_request = RX_HOLD_CYCLES;
		for (k = 4; k < 8; k++)
			random_setting(k);

		wait_for_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (k = 8; k < 12; k++)
			random_setting(k);

		wait_for_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
